FILE: rtl/dsfp_pkg.sv
// ----------------------------------------------------------------------------
// dsfp_pkg
// Shared types and constants for the dust sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dsfp_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 32;

  // Frame index width: holds every index up to the largest frame of 64 bytes
  localparam int unsigned CNT_W = 6;

  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;
  localparam logic [15:0] EXPECTED_LEN = 16'd28;
  localparam logic [15:0] HDR_SUM = 16'(HDR_FIRST) + 16'(HDR_SECOND);

  // Frame byte positions
  localparam logic [CNT_W-1:0] IDX_FIRST_BODY = 6'd2;
  localparam logic [CNT_W-1:0] IDX_LEN_HI   = 6'd2;
  localparam logic [CNT_W-1:0] IDX_LEN_LO   = 6'd3;
  localparam logic [CNT_W-1:0] IDX_SMALL_HI = 6'd10;
  localparam logic [CNT_W-1:0] IDX_SMALL_LO = 6'd11;
  localparam logic [CNT_W-1:0] IDX_MED_HI   = 6'd12;
  localparam logic [CNT_W-1:0] IDX_MED_LO   = 6'd13;
  localparam logic [CNT_W-1:0] IDX_LARGE_HI = 6'd14;
  localparam logic [CNT_W-1:0] IDX_LARGE_LO = 6'd15;
  localparam logic [CNT_W-1:0] IDX_SUM_LAST = 6'd29;
  localparam logic [CNT_W-1:0] IDX_CHK_HI   = 6'd30;
  localparam logic [CNT_W-1:0] IDX_CHK_LO   = 6'd31;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SECOND = 2'd1,
    PH_FRAME  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_LEN = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] pm_small;
    logic [15:0] pm_medium;
    logic [15:0] pm_large;
    status_e     frame_status;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/dust_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// dust_sensor_frame_parser
// Parses serial dust sensor frames into particle readings and a status.
// ----------------------------------------------------------------------------
// Input stream: one received byte per beat on s_axis_tdata_i. The parser hunts
// for the header 0x42 0x4D, reads the big-endian length word and closes the
// frame after 4 plus that length bytes, capped at FRAME_BYTES.
// Output stream: one beat per closed frame. tdata carries the three readings,
// tuser the status (ok, checksum mismatch, length word not 28); readings are
// zero unless the status is ok.
// Throughput: one byte per cycle while s_axis_tready_o is high; every input
// beat is handled in the cycle it is taken by the frame state registers.
// Result path: the closing byte's result is registered in the output buffer.
// Stall: a two-entry output buffer (result register plus skid stage) holds
// results; s_axis_tready_o drops only while both entries are full.
// Reset: the parser hunts for a header and the output buffer is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module dust_sensor_frame_parser import dsfp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [47:0] m_axis_tdata_o,   // [15:0] pm_small, [31:16] pm_medium,
                                             // [47:32] pm_large
  output      logic [1:0]  m_axis_tuser_o    // [1:0] frame_status
);

  logic beat;
  logic res_valid;
  logic space;
  res_t res;
  res_t out_res;

  assign s_axis_tready_o = space;
  assign beat            = s_axis_tvalid_i && space;

  dsfp_parse #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .rx_byte_i   (s_axis_tdata_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dsfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (out_res)
  );

  assign m_axis_tdata_o = {out_res.pm_large, out_res.pm_medium, out_res.pm_small};
  assign m_axis_tuser_o = out_res.frame_status;

endmodule

`default_nettype wire

FILE: rtl/dsfp_parse.sv
// ----------------------------------------------------------------------------
// dsfp_parse
// Header hunt, frame byte tracking, checksum and reading capture.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_parse import dsfp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       beat_i,
  input  wire logic [7:0] rx_byte_i,
  output      logic       res_valid_o,
  output      res_t       res_o
);

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      sum_q, sum_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      chk_q, chk_d;
  logic [15:0]      small_q, small_d;
  logic [15:0]      med_q, med_d;
  logic [15:0]      large_q, large_d;

  logic             in_frame;
  logic             start_frame;
  logic             frame_end;
  logic [16:0]      flen_raw;
  logic [16:0]      flen;
  logic [16:0]      idx_next;
  status_e          status;

  assign in_frame    = (phase_q == PH_FRAME);
  assign start_frame = beat_i && (phase_q == PH_SECOND) && (rx_byte_i == HDR_SECOND);

  // Field capture for the byte at the current frame index
  always_comb begin
    sum_d   = sum_q;
    len_d   = len_q;
    chk_d   = chk_q;
    small_d = small_q;
    med_d   = med_q;
    large_d = large_q;
    if (count_q <= IDX_SUM_LAST) begin
      sum_d = sum_q + 16'(rx_byte_i);
    end
    unique case (count_q)
      IDX_LEN_HI:   len_d   = {rx_byte_i, len_q[7:0]};
      IDX_LEN_LO:   len_d   = {len_q[15:8], rx_byte_i};
      IDX_SMALL_HI: small_d = {rx_byte_i, small_q[7:0]};
      IDX_SMALL_LO: small_d = {small_q[15:8], rx_byte_i};
      IDX_MED_HI:   med_d   = {rx_byte_i, med_q[7:0]};
      IDX_MED_LO:   med_d   = {med_q[15:8], rx_byte_i};
      IDX_LARGE_HI: large_d = {rx_byte_i, large_q[7:0]};
      IDX_LARGE_LO: large_d = {large_q[15:8], rx_byte_i};
      IDX_CHK_HI:   chk_d   = {rx_byte_i, chk_q[7:0]};
      IDX_CHK_LO:   chk_d   = {chk_q[15:8], rx_byte_i};
      default: ;
    endcase
  end

  // Frame length from the length word, capped at the frame buffer size
  always_comb begin
    flen_raw = {1'b0, len_d} + 17'd4;
    flen     = (flen_raw > 17'(FRAME_BYTES)) ? 17'(FRAME_BYTES) : flen_raw;
    idx_next = 17'(count_q) + 17'd1;
  end

  assign frame_end = in_frame && (count_q >= IDX_LEN_LO) && (idx_next >= flen);

  // Next phase and frame index
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    if (beat_i) begin
      unique case (phase_q)
        PH_SECOND: begin
          if (rx_byte_i == HDR_SECOND) begin
            phase_d = PH_FRAME;
            count_d = IDX_FIRST_BODY;
          end else if (rx_byte_i == HDR_FIRST) begin
            phase_d = PH_SECOND;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_FRAME: begin
          if (frame_end) begin
            phase_d = PH_HUNT;
            count_d = '0;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        default: begin
          phase_d = (rx_byte_i == HDR_FIRST) ? PH_SECOND : PH_HUNT;
          count_d = '0;
        end
      endcase
    end
  end

  // Result of the closing byte
  always_comb begin
    if (len_d != EXPECTED_LEN) begin
      status = ST_BAD_LEN;
    end else if (sum_d != chk_d) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_OK;
    end
    res_valid_o        = beat_i && frame_end;
    res_o.frame_status = status;
    res_o.pm_small     = (status == ST_OK) ? small_d : 16'd0;
    res_o.pm_medium    = (status == ST_OK) ? med_d   : 16'd0;
    res_o.pm_large     = (status == ST_OK) ? large_d : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // Clear the frame fields on a recognized header, else capture in frame
  always_ff @(posedge clk_i) begin
    if (start_frame) begin
      sum_q   <= HDR_SUM;
      len_q   <= '0;
      chk_q   <= '0;
      small_q <= '0;
      med_q   <= '0;
      large_q <= '0;
    end else if (beat_i && in_frame) begin
      sum_q   <= sum_d;
      len_q   <= len_d;
      chk_q   <= chk_d;
      small_q <= small_d;
      med_q   <= med_d;
      large_q <= large_d;
    end
  end

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame |-> ({1'b0, count_q} < 7'(FRAME_BYTES)))
    else $error("frame index beyond frame size");

  a_result_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (in_frame && count_q >= IDX_LEN_LO))
    else $error("result outside a frame");

  a_header_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_frame |=> (phase_q == PH_FRAME && count_q == IDX_FIRST_BODY))
    else $error("header did not open a frame at index two");

  a_end_resyncs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (phase_q == PH_HUNT && count_q == '0))
    else $error("parser did not resync after a frame");

endmodule

`default_nettype wire

FILE: rtl/dsfp_out_buf.sv
// ----------------------------------------------------------------------------
// dsfp_out_buf
// Result register with a skid stage toward the downstream stream.
// ----------------------------------------------------------------------------
`default_nettype none

module dsfp_out_buf import dsfp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t push_data_i,
  output      logic space_o,
  output      logic valid_o,
  input  wire logic ready_i,
  output      res_t data_o
);

  logic main_valid_q;
  logic skid_valid_q;
  res_t main_q;
  res_t skid_q;
  logic pop;

  assign pop     = main_valid_q && ready_i;
  assign space_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!main_valid_q || pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          main_valid_q <= push_i;
        end
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || pop) begin
      main_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid stage holds a beat ahead of the result register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed into a full buffer");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (main_valid_q && !skid_valid_q))
    else $error("skid stage did not move into the result register");

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dust sensor frame parser.
// ----------------------------------------------------------------------------
// Feeds header-framed byte streams into the slave stream. Most of them are
// well-formed frames with random content, and the rest are bad checksums,
// bad length words, broken headers and noise. A scoreboard tracks the frame
// state for every byte taken and queues the reading it expects. Each output
// beat is compared field by field with the oldest queued reading. Both sides
// throttle at random in three phases: light sender gaps with heavy sink
// stalls, then the reverse, then full rate.
// ----------------------------------------------------------------------------
module tb;
  import dsfp_pkg::*;

  localparam int unsigned FRAME_N = FRAME_BYTES_DEF;

  class frame_tracker;
    phase_e      phase;
    logic [5:0]  count;
    logic [15:0] sum;
    logic [15:0] length_q;
    logic [15:0] check_q;
    logic [15:0] small_q;
    logic [15:0] medium_q;
    logic [15:0] large_q;
    res_t        readings_q[$];
    int unsigned errors;

    function new();
      phase    = PH_HUNT;
      count    = '0;
      sum      = '0;
      length_q = '0;
      check_q  = '0;
      small_q  = '0;
      medium_q = '0;
      large_q  = '0;
      errors   = 0;
    endfunction

    // Advance the frame state by one accepted byte and queue any reading.
    function void take_byte(logic [7:0] b);
      int unsigned flen;
      res_t        r;
      case (phase)
        PH_SECOND: begin
          if (b == HDR_SECOND) begin
            phase    = PH_FRAME;
            count    = IDX_FIRST_BODY;
            sum      = HDR_SUM;
            length_q = '0;
            check_q  = '0;
            small_q  = '0;
            medium_q = '0;
            large_q  = '0;
          end else if (b == HDR_FIRST) begin
            phase = PH_SECOND;
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_FRAME: begin
          if (count <= IDX_SUM_LAST) sum = sum + 16'(b);
          case (count)
            IDX_LEN_HI:   length_q[15:8] = b;
            IDX_LEN_LO:   length_q[7:0]  = b;
            IDX_SMALL_HI: small_q[15:8]  = b;
            IDX_SMALL_LO: small_q[7:0]   = b;
            IDX_MED_HI:   medium_q[15:8] = b;
            IDX_MED_LO:   medium_q[7:0]  = b;
            IDX_LARGE_HI: large_q[15:8]  = b;
            IDX_LARGE_LO: large_q[7:0]   = b;
            IDX_CHK_HI:   check_q[15:8]  = b;
            IDX_CHK_LO:   check_q[7:0]   = b;
            default: ;
          endcase
          flen = 32'(length_q) + 4;
          if (flen > FRAME_N) flen = FRAME_N;
          if (count >= IDX_LEN_LO && 32'(count) + 1 >= flen) begin
            if (length_q != EXPECTED_LEN) r.frame_status = ST_BAD_LEN;
            else if (sum != check_q)      r.frame_status = ST_BAD_SUM;
            else                          r.frame_status = ST_OK;
            // Readings are zeroed on any error
            r.pm_small  = (r.frame_status == ST_OK) ? small_q  : '0;
            r.pm_medium = (r.frame_status == ST_OK) ? medium_q : '0;
            r.pm_large  = (r.frame_status == ST_OK) ? large_q  : '0;
            readings_q.push_back(r);
            phase = PH_HUNT;
            count = '0;
          end else begin
            count = count + 1'b1;
          end
        end
        default: begin
          phase = (b == HDR_FIRST) ? PH_SECOND : PH_HUNT;
          count = '0;
        end
      endcase
    endfunction

    function void check_reading(logic [47:0] data, logic [1:0] user);
      res_t r;
      if (readings_q.size() == 0) begin
        $display("%0t: unexpected output beat data=%h status=%0d", $time, data, user);
        errors++;
        return;
      end
      r = readings_q.pop_front();
      if (data[15:0] != r.pm_small) begin
        $display("%0t: pm_small expected %h actual %h", $time, r.pm_small, data[15:0]);
        errors++;
      end
      if (data[31:16] != r.pm_medium) begin
        $display("%0t: pm_medium expected %h actual %h", $time, r.pm_medium, data[31:16]);
        errors++;
      end
      if (data[47:32] != r.pm_large) begin
        $display("%0t: pm_large expected %h actual %h", $time, r.pm_large, data[47:32]);
        errors++;
      end
      if (user != r.frame_status) begin
        $display("%0t: frame_status expected %0d actual %0d", $time, r.frame_status, user);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return readings_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic [7:0]  s_tdata;
  logic        m_tready;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [47:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  int unsigned  src_idle_pct;
  int unsigned  snk_idle_pct;
  int unsigned  frame_bytes;
  frame_tracker tracker;

  dust_sensor_frame_parser #(
    .FRAME_BYTES(FRAME_N)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Output side: check each taken beat, then throttle tready.
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_tready) tracker.check_reading(m_axis_tdata_o, m_axis_tuser_o);
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.take_byte(b);
  endtask

  // Build a frame with the given length word; flip corrupts the checksum.
  task automatic send_frame(input logic [15:0] len, input logic [15:0] flip);
    logic [7:0]  fr [0:63];
    logic [15:0] csum;
    int unsigned flen;
    fr[0] = HDR_FIRST;
    fr[1] = HDR_SECOND;
    fr[2] = len[15:8];
    fr[3] = len[7:0];
    for (int i = 4; i < 64; i++) begin
      case ($urandom_range(7))
        0:       fr[i] = 8'h00;
        1:       fr[i] = 8'hFF;
        default: fr[i] = 8'($urandom_range(255));
      endcase
    end
    csum = '0;
    for (int i = 0; i <= int'(IDX_SUM_LAST); i++) csum = csum + 16'(fr[i]);
    csum = csum ^ flip;
    fr[IDX_CHK_HI] = csum[15:8];
    fr[IDX_CHK_LO] = csum[7:0];
    flen = 32'(len) + 4;
    if (flen > FRAME_N) flen = FRAME_N;
    for (int i = 0; i < int'(flen); i++) send_byte(fr[i]);
    frame_bytes += flen;
  endtask

  initial begin
    int unsigned sel;
    int unsigned n;
    logic [7:0]  nb;
    logic [15:0] blen;
    tracker      = new();
    rst_ni       = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    src_idle_pct = 19;
    snk_idle_pct = 63;
    frame_bytes  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored bytes, broken headers, shortest frames
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_FIRST);
    send_byte(8'h00);
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(HDR_SECOND);
    send_byte(8'h4C);
    send_byte(HDR_FIRST);
    send_byte(8'h43);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 19;
          snk_idle_pct = 63;
        end
        1: begin
          src_idle_pct = 63;
          snk_idle_pct = 19;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      while (frame_bytes < 600 * (ph + 1)) begin
        if ($urandom_range(9) < 3) begin
          n = $urandom_range(1, 6);
          repeat (n) send_byte(8'($urandom_range(255)));
        end
        sel = $urandom_range(99);
        if (sel < 60) begin
          send_frame(EXPECTED_LEN, 16'h0000);
        end else if (sel < 75) begin
          send_frame(EXPECTED_LEN, 16'($urandom_range(1, 65535)));
        end else if (sel < 90) begin
          case ($urandom_range(5))
            0:       blen = 16'($urandom_range(3));
            1:       blen = 16'd27;
            2:       blen = 16'd29;
            3:       blen = 16'hFFFF;
            default: blen = 16'($urandom_range(65535));
          endcase
          if (blen == EXPECTED_LEN) blen = 16'd29;
          send_frame(blen, 16'h0000);
        end else begin
          // Drop a header half-way, then resync on a good frame
          nb = 8'($urandom_range(255));
          if (nb == HDR_SECOND) nb = 8'h00;
          send_byte(HDR_FIRST);
          send_byte(nb);
          send_frame(EXPECTED_LEN, 16'h0000);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("dust_sensor_frame_parser test passed");
    end else begin
      $display("dust_sensor_frame_parser test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("dust_sensor_frame_parser test failed");
    $finish;
  end
endmodule

FILE: dust_sensor_frame_parser.f
rtl/dsfp_pkg.sv
rtl/dsfp_parse.sv
rtl/dsfp_out_buf.sv
rtl/dust_sensor_frame_parser.sv
bench/tb.sv
